// ===== src/mnee_pkg.sv =====
package mnee_pkg;

  localparam int unsigned TickW = 28;
  localparam int unsigned TpsW  = 12;
  localparam int unsigned ProdW = 44;
  localparam int unsigned FracW = 16;

  localparam logic [TpsW-1:0] TPS_RESET = 12'd480;

  localparam logic FUNC_NOTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] BYTE_META       = 8'hFF;
  localparam logic [7:0] BYTE_EOT        = 8'h2F;

  localparam logic [2:0] END_LAST_IDX = 3'd3;

  typedef struct packed {
    logic       func;
    logic [31:0] time_seconds;
    logic [6:0] instrument;
    logic       is_off;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] track_length;
  } out_item_t;

  typedef struct packed {
    logic             func;
    logic [TickW-1:0] delta;
    logic [1:0]       ngrp_m1;
    logic [7:0]       status;
    logic [6:0]       note;
    logic [6:0]       velocity;
  } qent_t;

endpackage

// ===== src/mnee_front.sv =====
module mnee_front import mnee_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [TpsW-1:0] tps_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output qent_t           push_data_o
);

  logic             a_valid_q;
  logic [TickW-1:0] a_tick_q;
  logic             a_func_q;
  logic [7:0]       a_status_q;
  logic [6:0]       a_note_q;
  logic [6:0]       a_vel_q;
  logic [TickW-1:0] prev_q, prev_d;

  logic [ProdW-1:0] prod;
  logic [3:0]       chan;
  logic             accept;
  logic             push_fire;
  logic [TickW-1:0] delta;

  assign in_stall_o = a_valid_q & ~push_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_fire  = a_valid_q & push_ready_i;

  assign prod = ProdW'(in_data_i.time_seconds) * ProdW'(tps_i);
  assign chan = in_data_i.instrument[3:0] - 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      prev_q    <= '0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (push_fire) begin
        a_valid_q <= 1'b0;
      end
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_tick_q   <= prod[FracW +: TickW];
      a_func_q   <= in_data_i.func;
      a_status_q <= {(in_data_i.is_off ? STATUS_NOTE_OFF : STATUS_NOTE_ON), chan};
      a_note_q   <= in_data_i.note;
      a_vel_q    <= in_data_i.velocity;
    end
  end

  assign delta = (a_tick_q >= prev_q) ? (a_tick_q - prev_q) : '0;

  always_comb begin
    prev_d = prev_q;
    if (push_fire) begin
      prev_d = (a_func_q == FUNC_END) ? '0 : a_tick_q;
    end
  end

  always_comb begin
    push_data_o.func     = a_func_q;
    push_data_o.delta    = delta;
    push_data_o.status   = a_status_q;
    push_data_o.note     = a_note_q;
    push_data_o.velocity = a_vel_q;
    if (delta[27:21] != '0) begin
      push_data_o.ngrp_m1 = 2'd3;
    end else if (delta[20:14] != '0) begin
      push_data_o.ngrp_m1 = 2'd2;
    end else if (delta[13:7] != '0) begin
      push_data_o.ngrp_m1 = 2'd1;
    end else begin
      push_data_o.ngrp_m1 = 2'd0;
    end
  end

  assign push_valid_o = a_valid_q;

endmodule

// ===== src/mnee_queue.sv =====
module mnee_queue import mnee_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  qent_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output qent_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qent_t         mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/mnee_back.sv =====
module mnee_back import mnee_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  qent_t     pop_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic        cur_valid_q;
  qent_t       cur_q;
  logic [2:0]  idx_q;
  logic [31:0] total_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [2:0]  ngrp;
  logic [2:0]  last_idx;
  logic        last;
  logic [1:0]  gsel;
  logic [6:0]  grp;
  logic [7:0]  cur_byte;
  logic        out_load;
  logic        pop_fire;
  logic [31:0] total_inc;

  assign ngrp     = {1'b0, cur_q.ngrp_m1};
  assign last_idx = (cur_q.func == FUNC_END) ? END_LAST_IDX : ngrp + 3'd3;
  assign last     = (idx_q == last_idx);
  assign gsel     = cur_q.ngrp_m1 - idx_q[1:0];

  always_comb begin
    unique case (gsel)
      2'd0:    grp = cur_q.delta[6:0];
      2'd1:    grp = cur_q.delta[13:7];
      2'd2:    grp = cur_q.delta[20:14];
      default: grp = cur_q.delta[27:21];
    endcase
  end

  always_comb begin
    if (cur_q.func == FUNC_END) begin
      unique case (idx_q)
        3'd1:    cur_byte = BYTE_META;
        3'd2:    cur_byte = BYTE_EOT;
        default: cur_byte = BYTE_ZERO;
      endcase
    end else if (idx_q <= ngrp) begin
      cur_byte = {(idx_q != ngrp), grp};
    end else if (idx_q == ngrp + 3'd1) begin
      cur_byte = cur_q.status;
    end else if (idx_q == ngrp + 3'd2) begin
      cur_byte = {1'b0, cur_q.note};
    end else begin
      cur_byte = {1'b0, cur_q.velocity};
    end
  end

  assign out_load    = cur_valid_q & (~out_valid_q | ~out_stall_i);
  assign pop_ready_o = ~cur_valid_q | (out_load & last);
  assign pop_fire    = pop_valid_i & pop_ready_o;
  assign total_inc   = (total_q == '1) ? total_q : total_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_fire) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (out_load && last) begin
        cur_valid_q <= 1'b0;
      end else if (out_load) begin
        idx_q <= idx_q + 3'd1;
      end
      if (out_load) begin
        total_q <= (cur_q.func == FUNC_END && last) ? '0 : total_inc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      cur_q <= pop_data_i;
    end
    if (out_load) begin
      out_q.out_byte     <= cur_byte;
      out_q.last_byte    <= last;
      out_q.track_length <= total_inc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/midi_note_event_encoder.sv =====
// Path: an item's first byte passes the front stage, the queue and the current-item
// register before the output register shows it. Throughput: one byte per cycle
// while out_stall_i is low; a note item gives 4 to 7 bytes, an end item 4.
// Reset: clears the last tick, the track byte count, the queue and all valids;
// ticks_per_second returns to 480.
module midi_note_event_encoder import mnee_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [TpsW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  logic [TpsW-1:0] tps_q;
  logic            push_valid, push_ready;
  qent_t           push_data;
  logic            pop_valid, pop_ready;
  qent_t           pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  mnee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tps_i        (tps_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mnee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mnee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/mnee_checker.sv =====
module mnee_checker import mnee_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o);
  endproperty

  property p_next_byte;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_stall_i && !out_data_o.last_byte |=>
        out_valid_o &&
        ((out_data_o.track_length == $past(out_data_o.track_length) + 32'd1) ||
         ($past(out_data_o.track_length) == '1 && out_data_o.track_length == '1));
  endproperty

  property p_length_nonzero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> out_data_o.track_length != '0;
  endproperty

  a_out_hold: assert property (p_out_hold)
    else $error("stalled output transaction changed");
  a_next_byte: assert property (p_next_byte)
    else $error("byte sequence broken within a transaction group");
  a_length_nonzero: assert property (p_length_nonzero)
    else $error("track length zero on a valid byte");

endmodule

bind midi_note_event_encoder mnee_checker u_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mnee_pkg::*;

  logic            clk = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [TpsW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_data_o;

  midi_note_event_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  localparam int unsigned QuietLimit = 3000;

  // encoder state mirror
  logic [TpsW-1:0]  rate_q        = TPS_RESET;
  logic [TickW-1:0] last_tick_q   = '0;
  logic [31:0]      track_count_q = '0;
  out_item_t        track_bytes_due[$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_req       = 0;
  int          hold_left      = 0;
  int          errors         = 0;
  int          notes_sent     = 0;
  int          ends_sent      = 0;
  int          bytes_checked  = 0;
  int          rates_used     = 0;
  int unsigned quiet          = 0;
  logic [31:0] next_time      = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic emit_byte(input logic [7:0] value, input logic last);
    out_item_t b;
    if (track_count_q != '1) track_count_q++;
    b.out_byte     = value;
    b.last_byte    = last;
    b.track_length = track_count_q;
    track_bytes_due.push_back(b);
  endtask

  task automatic encode_event(input in_item_t it);
    logic [ProdW-1:0] product;
    logic [TickW-1:0] tick;
    logic [TickW-1:0] delta;
    logic [3:0]       chan;
    int               ngrp;
    if (it.func == FUNC_END) begin
      emit_byte(BYTE_ZERO, 1'b0);
      emit_byte(BYTE_META, 1'b0);
      emit_byte(BYTE_EOT, 1'b0);
      emit_byte(BYTE_ZERO, 1'b1);
      last_tick_q   = '0;
      track_count_q = '0;
      ends_sent++;
    end else begin
      product     = it.time_seconds * rate_q;
      tick        = product[ProdW-1:FracW];
      delta       = (tick >= last_tick_q) ? tick - last_tick_q : '0;
      last_tick_q = tick;
      ngrp = (delta >= 28'd2097152) ? 4 : (delta >= 28'd16384) ? 3 : (delta >= 28'd128) ? 2 : 1;
      for (int k = ngrp - 1; k > 0; k--) emit_byte({1'b1, delta[7*k +: 7]}, 1'b0);
      emit_byte({1'b0, delta[6:0]}, 1'b0);
      chan = it.instrument[3:0] - 4'd1;
      emit_byte({(it.is_off ? STATUS_NOTE_OFF : STATUS_NOTE_ON), chan}, 1'b0);
      emit_byte({1'b0, it.note}, 1'b0);
      emit_byte({1'b0, it.velocity}, 1'b1);
      notes_sent++;
    end
  endtask

  function automatic in_item_t make_note(input logic [31:0] t, input logic [6:0] instr,
                                         input logic off, input logic [6:0] note,
                                         input logic [6:0] vel);
    in_item_t it;
    it.func         = FUNC_NOTE;
    it.time_seconds = t;
    it.instrument   = instr;
    it.is_off       = off;
    it.note         = note;
    it.velocity     = vel;
    return it;
  endfunction

  function automatic in_item_t end_marker();
    in_item_t it;
    it      = make_note($urandom, 7'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
    it.func = FUNC_END;
    return it;
  endfunction

  function automatic in_item_t random_event();
    in_item_t    it;
    int          pick;
    logic [32:0] sum;
    it = make_note('0, ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100, 1)),
                   1'($urandom), 7'($urandom), 7'($urandom));
    pick = $urandom_range(99);
    if (pick < 7) begin
      it = end_marker();
      next_time = '0;
      return it;
    end else if (pick < 15) begin
      it.time_seconds = $urandom;
    end else if (pick < 22) begin
      it.time_seconds = $urandom_range(next_time, 0);
    end else begin
      sum = next_time + ($urandom >> $urandom_range(31, 5));
      it.time_seconds = sum[32] ? '1 : sum[31:0];
    end
    next_time = it.time_seconds;
    return it;
  endfunction

  task automatic send_event(input in_item_t it);
    logic taken;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall_o;
      @(posedge clk);
    end while (!taken);
    encode_event(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (track_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [TpsW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    rate_q = value;
    rates_used++;
  endtask

  task automatic test_reset_rate();
    send_event(make_note(32'h0000_0000, 7'd1, 1'b0, 7'd60, 7'd100));
    send_event(make_note(32'h0001_0000, 7'd0, 1'b1, 7'd60, 7'd0));
    send_event(make_note(32'hFFFF_FFFF, 7'd127, 1'b0, 7'd127, 7'd127));
    drain();
  endtask

  task automatic test_vlq_bounds();
    int unsigned steps[7] = '{0, 127, 128, 16383, 16384, 2097151, 2097152};
    logic [31:0] tick;
    write_rate(12'd2048);
    send_event(end_marker());
    tick = '0;
    foreach (steps[k]) begin
      tick = tick + steps[k];
      send_event(make_note({tick[26:0], 5'($urandom)}, 7'd5, 1'b0, 7'($urandom), 7'($urandom)));
    end
    drain();
  endtask

  task automatic test_backward_time();
    write_rate(12'd4095);
    send_event(make_note(32'h8000_0000, 7'd2, 1'b0, 7'd64, 7'd90));
    send_event(make_note(32'h0000_1234, 7'd2, 1'b1, 7'd64, 7'd0));
    send_event(make_note(32'h0000_2000, 7'd2, 1'b0, 7'd65, 7'd80));
    drain();
  endtask

  task automatic test_channels();
    send_event(make_note(32'h0000_3000, 7'd16, 1'b0, 7'h55, 7'h2A));
    send_event(make_note(32'h0000_4000, 7'd17, 1'b1, 7'h2A, 7'h55));
    send_event(make_note(32'h0000_4000, 7'd100, 1'b0, 7'd0, 7'd127));
    send_event(end_marker());
    drain();
  endtask

  task automatic test_zero_rate();
    write_rate(12'd0);
    send_event(make_note(32'hFFFF_FFFF, 7'd9, 1'b0, 7'd40, 7'd1));
    send_event(make_note(32'h1234_5678, 7'd9, 1'b1, 7'd40, 7'd0));
    send_event(end_marker());
    drain();
  endtask

  task automatic test_backpressure();
    write_rate(12'd4095);
    hold_req = 80;
    repeat (16) send_event(random_event());
    drain();
  endtask

  task automatic test_random_phase(input int count, input int send_pct, input int stall_pct,
                                   input logic [TpsW-1:0] rate);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    write_rate(rate);
    repeat (count) send_event(random_event());
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(negedge clk) begin : check_byte
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (track_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %02h", $time, out_data_o.out_byte);
      end else begin
        want = track_bytes_due.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
                   out_data_o.out_byte);
        end
        if (out_data_o.last_byte !== want.last_byte) begin
          errors++;
          $display("%0t: last_byte expected %0b got %0b", $time, want.last_byte,
                   out_data_o.last_byte);
        end
        if (out_data_o.track_length !== want.track_length) begin
          errors++;
          $display("%0t: track_length expected %0d got %0d", $time, want.track_length,
                   out_data_o.track_length);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else if (++quiet >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_rate();
    test_vlq_bounds();
    test_backward_time();
    test_channels();
    test_zero_rate();
    test_backpressure();
    test_random_phase(43, 0, 0, 12'd4095);
    test_random_phase(43, 57, 0, 12'd1);
    test_random_phase(43, 0, 57, 12'($urandom_range(4094, 2)));
    test_random_phase(43, 30, 30, 12'd480);

    repeat (20) @(posedge clk);
    $display("Sent %0d note events and %0d end markers over %0d rate settings,",
             notes_sent, ends_sent, rates_used);
    $display("checked %0d track bytes with idle, stall and long hold-off phases.",
             bytes_checked);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
